FILE: src/row_gap_midpoint_finder_top_macros.svh
// assertion macros used by the checker file
`ifndef ROW_GAP_MIDPOINT_FINDER_TOP_MACROS_SVH
`define ROW_GAP_MIDPOINT_FINDER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RGMF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgmf check failed");

// next-cycle implication, disabled while in reset
`define RGMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgmf check failed");

`endif

FILE: src/rgmf_pkg.sv
// shared constants and types of the row gap midpoint finder
package rgmf_pkg;

	localparam int MAX_ROWS = 4096;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int PIX_W    = 8;

	localparam logic [PIX_W-1:0] WHITE_LEVEL     = {PIX_W{1'b1}};
	localparam logic [ROW_W-1:0] START_ROW_RESET = ROW_W'(70);
	localparam logic [ROW_W-1:0] ROW_LAST        = ROW_W'(MAX_ROWS - 1);

	typedef struct packed {
		logic [ROW_W-1:0] gap_length;
		logic [ROW_W-1:0] mid_row;
	} result_t;

endpackage

FILE: src/rgmf_core.sv
// input register, per-row gap tracking and best-gap selection
module rgmf_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rgmf_pkg::ROW_W-1:0] start_row,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rgmf_pkg::PIX_W-1:0] in_pixel,
	input  logic                      in_row_end,
	input  logic                      in_frame_end,
	input  logic                      res_space,
	output logic                      res_valid,
	output rgmf_pkg::result_t         res
);
	import rgmf_pkg::*;

	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             row_end_s1;
	logic             frame_end_s1;

	logic [ROW_W-1:0] row_index_q;
	logic             row_all_white_q;
	logic             gap_open_q;
	logic [ROW_W-1:0] gap_start_row_q;
	logic [ROW_W-1:0] best_gap_length_q;
	logic [ROW_W-1:0] best_mid_row_q;

	logic             fire;
	logic             white_now;
	logic             row_done;
	logic             examined;
	logic [ROW_W-1:0] len;
	logic [ROW_W:0]   mid_sum;
	logic             open_gap;
	logic             close_gap;
	logic             better;
	logic [ROW_W-1:0] best_len_nx;
	logic [ROW_W-1:0] best_mid_nx;

	assign fire     = valid_s1 && (!frame_end_s1 || res_space);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pixel_s1     <= in_pixel;
			row_end_s1   <= in_row_end;
			frame_end_s1 <= in_frame_end;
		end
	end

	always_comb begin
		white_now   = row_all_white_q && (pixel_s1 == WHITE_LEVEL);
		row_done    = row_end_s1 || frame_end_s1;
		examined    = row_index_q >= start_row;
		len         = row_index_q - gap_start_row_q;
		mid_sum     = {1'b0, gap_start_row_q} + {1'b0, row_index_q};
		open_gap    = row_done && examined && white_now && !gap_open_q;
		close_gap   = row_done && examined && !white_now && gap_open_q;
		better      = close_gap && (len > best_gap_length_q);
		best_len_nx = better ? len : best_gap_length_q;
		best_mid_nx = better ? mid_sum[ROW_W:1] : best_mid_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_index_q       <= '0;
			row_all_white_q   <= 1'b1;
			gap_open_q        <= 1'b0;
			gap_start_row_q   <= '0;
			best_gap_length_q <= '0;
			best_mid_row_q    <= '0;
		end else if (fire) begin
			if (frame_end_s1) begin
				row_index_q       <= '0;
				row_all_white_q   <= 1'b1;
				gap_open_q        <= 1'b0;
				gap_start_row_q   <= '0;
				best_gap_length_q <= '0;
				best_mid_row_q    <= '0;
			end else if (row_done) begin
				if (row_index_q != ROW_LAST) begin
					row_index_q <= row_index_q + ROW_W'(1);
				end
				row_all_white_q   <= 1'b1;
				best_gap_length_q <= best_len_nx;
				best_mid_row_q    <= best_mid_nx;
				if (open_gap) begin
					gap_open_q      <= 1'b1;
					gap_start_row_q <= row_index_q;
				end else if (close_gap) begin
					gap_open_q <= 1'b0;
				end
			end else begin
				row_all_white_q <= white_now;
			end
		end
	end

	assign res_valid      = fire && frame_end_s1;
	assign res.mid_row    = best_mid_nx;
	assign res.gap_length = best_len_nx;

endmodule

FILE: src/rgmf_out_reg.sv
// result register on the output stream
module rgmf_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	input  rgmf_pkg::result_t           res,
	output logic                        res_space,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2*rgmf_pkg::ROW_W-1:0] out_data
);
	import rgmf_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign res_space = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_space) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_space && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: src/row_gap_midpoint_finder_top.sv
// top level of the row gap midpoint finder
//
// pixels of a grayscale frame enter in raster order on the s_axis stream, one
// transaction per pixel: tdata carries the pixel, tuser marks the last pixel
// of a row and tlast the last pixel of the frame (which also ends its row).
// rows from start_row on are checked for being all white; the widest closed
// run of white rows is found and, once per frame, one transaction on m_axis
// gives its floored midpoint row and its length, both zero if no run closed.
// start_row is written on the cfg channel, always ready; the user must write it
// only while idle; the block does not enforce it. results leave via an output register.
// throughput: one pixel per cycle, set by the single input register stage.
// a waiting result does not stop pixels; only a second frame end held behind
// an untaken result stalls the input until the result is taken.
// reset clears all frame state and sets start_row to 70, with no clearing pass.
module row_gap_midpoint_finder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rgmf_pkg::ROW_W-1:0]   cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rgmf_pkg::PIX_W-1:0]   s_axis_tdata,  // pixel
	input  logic                        s_axis_tuser,  // row_end
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [2*rgmf_pkg::ROW_W-1:0] m_axis_tdata   // gap_length (upper half), mid_row (lower half)
);
	import rgmf_pkg::*;

	logic [ROW_W-1:0] start_row_q;
	logic             res_valid;
	logic             res_space;
	result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= START_ROW_RESET;
		end else if (cfg_valid) begin
			start_row_q <= cfg_data;
		end
	end

	rgmf_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_row    (start_row_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_pixel     (s_axis_tdata),
		.in_row_end   (s_axis_tuser),
		.in_frame_end (s_axis_tlast),
		.res_space    (res_space),
		.res_valid    (res_valid),
		.res          (res)
	);

	rgmf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_space (res_space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: src/rgmf_checker.sv
// port-level checks on the row gap midpoint finder, bound to the top level
`include "row_gap_midpoint_finder_top_macros.svh"

module rgmf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        s_axis_tlast,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [2*rgmf_pkg::ROW_W-1:0] m_axis_tdata
);
	import rgmf_pkg::*;

	logic             last_taken;
	logic [ROW_W-1:0] mid_row;
	logic [ROW_W-1:0] gap_length;

	assign last_taken = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign mid_row    = m_axis_tdata[ROW_W-1:0];
	assign gap_length = m_axis_tdata[2*ROW_W-1:ROW_W];

	`RGMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`RGMF_ASSERT_NOW(a_rise_after_last, $rose(m_axis_tvalid), $past(last_taken, 2))
	`RGMF_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
	`RGMF_ASSERT_NOW(a_mid_bound, m_axis_tvalid, mid_row >= (gap_length >> 1))
	`RGMF_ASSERT_NOW(a_no_gap_zero, m_axis_tvalid && gap_length == '0, mid_row == '0)

endmodule

bind row_gap_midpoint_finder_top rgmf_checker u_rgmf_checker (.*);

FILE: verif/row_gap_midpoint_finder_top_test.sv
// self-checking testbench for the row gap midpoint finder, random frames against a predictor
module row_gap_midpoint_finder_top_test;

	typedef struct packed {
		logic [rgmf_pkg::PIX_W-1:0] pixel;
		logic                       row_end;
		logic                       frame_end;
	} pixel_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [rgmf_pkg::ROW_W-1:0]    cfg_data = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [rgmf_pkg::PIX_W-1:0]    s_axis_tdata = '0;
	logic                          s_axis_tuser = 1'b0;
	logic                          s_axis_tlast = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [2*rgmf_pkg::ROW_W-1:0]  m_axis_tdata;

	// pixels waiting for the driver, frame results waiting for the monitor
	pixel_item_t           pixel_q[$];
	rgmf_pkg::result_t     gap_results_q[$];
	pixel_item_t           drv_item;
	rgmf_pkg::result_t     want_res;
	rgmf_pkg::result_t     got_res;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int pixels_queued = 0;
	int results_checked = 0;
	int settings_written = 0;

	// predictor state
	logic [rgmf_pkg::ROW_W-1:0] m_start_row = rgmf_pkg::START_ROW_RESET;
	logic [rgmf_pkg::ROW_W-1:0] cur_row = '0;
	logic                       row_white = 1'b1;
	logic                       gap_is_open = 1'b0;
	logic [rgmf_pkg::ROW_W-1:0] gap_first_row = '0;
	logic [rgmf_pkg::ROW_W-1:0] widest_len = '0;
	logic [rgmf_pkg::ROW_W-1:0] widest_mid = '0;

	row_gap_midpoint_finder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// widest closed white-row gap of the frame, emitted on the frame end pixel
	function automatic void track_row_gaps(logic [rgmf_pkg::PIX_W-1:0] pix, logic re, logic fe);
		rgmf_pkg::result_t          res;
		logic [rgmf_pkg::ROW_W-1:0] span;
		if (pix != rgmf_pkg::WHITE_LEVEL) row_white = 1'b0;
		if (re || fe) begin
			if (cur_row >= m_start_row) begin
				if (row_white && !gap_is_open) begin
					gap_is_open = 1'b1;
					gap_first_row = cur_row;
				end else if (!row_white && gap_is_open) begin
					span = cur_row - gap_first_row;
					gap_is_open = 1'b0;
					if (span > widest_len) begin
						widest_len = span;
						widest_mid = rgmf_pkg::ROW_W'(({1'b0, gap_first_row} + {1'b0, cur_row}) >> 1);
					end
				end
			end
			if (cur_row != rgmf_pkg::ROW_LAST) cur_row = cur_row + 1'b1;
			row_white = 1'b1;
		end
		if (fe) begin
			res.mid_row = widest_mid;
			res.gap_length = widest_len;
			gap_results_q.push_back(res);
			cur_row = '0;
			row_white = 1'b1;
			gap_is_open = 1'b0;
			gap_first_row = '0;
			widest_len = '0;
			widest_mid = '0;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				drv_item = pixel_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= drv_item.pixel;
				s_axis_tuser <= drv_item.row_end;
				s_axis_tlast <= drv_item.frame_end;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: tracks config and pixel transactions, checks result transactions
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
			if (cfg_valid && cfg_ready) m_start_row = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				track_row_gaps(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got_res = rgmf_pkg::result_t'(m_axis_tdata);
				if (gap_results_q.size() == 0) begin
					$error("unexpected result: mid_row %0d gap_length %0d",
						got_res.mid_row, got_res.gap_length);
					fail_count++;
				end else begin
					want_res = gap_results_q.pop_front();
					if (got_res.mid_row != want_res.mid_row) begin
						$error("mid_row expected %0d, got %0d", want_res.mid_row, got_res.mid_row);
						fail_count++;
					end
					if (got_res.gap_length != want_res.gap_length) begin
						$error("gap_length expected %0d, got %0d",
							want_res.gap_length, got_res.gap_length);
						fail_count++;
					end
					results_checked++;
				end
			end
		end
	end

	task automatic queue_pixel(input logic [rgmf_pkg::PIX_W-1:0] pix, input logic re,
			input logic fe);
		pixel_item_t it;
		it.pixel = pix;
		it.row_end = re;
		it.frame_end = fe;
		pixel_q.push_back(it);
		pixels_queued++;
	endtask

	// frame of fixed width; a dark row has at least one pixel below white
	task automatic queue_frame(input int n_rows, input int width, input int white_pct,
			input bit drop_row_end);
		int  r;
		int  c;
		int  dark_col;
		bit  is_white;
		bit  last_col;
		bit  last_px;
		logic [rgmf_pkg::PIX_W-1:0] pix;
		for (r = 0; r < n_rows; r++) begin
			is_white = ($urandom_range(99, 0) < white_pct);
			dark_col = $urandom_range(width - 1, 0);
			for (c = 0; c < width; c++) begin
				if (is_white)
					pix = rgmf_pkg::WHITE_LEVEL;
				else if (c == dark_col)
					pix = rgmf_pkg::PIX_W'($urandom_range(254, 0));
				else
					pix = $urandom_range(1, 0) ? rgmf_pkg::WHITE_LEVEL
						: rgmf_pkg::PIX_W'($urandom_range(255, 0));
				last_col = (c == width - 1);
				last_px = last_col && (r == n_rows - 1);
				queue_pixel(pix, last_col && !(last_px && drop_row_end), last_px);
			end
		end
	endtask

	// ragged rows and random pixels
	task automatic queue_noise_frame(input int n_px);
		int i;
		for (i = 0; i < n_px; i++)
			queue_pixel($urandom_range(1, 0) ? rgmf_pkg::WHITE_LEVEL
				: rgmf_pkg::PIX_W'($urandom_range(255, 0)),
				$urandom_range(2, 0) == 0, i == n_px - 1);
	endtask

	task automatic wait_idle();
		while (pixel_q.size() != 0 || s_axis_tvalid) @(negedge clk);
		while (gap_results_q.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_row(input logic [rgmf_pkg::ROW_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 83;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 25;
				recv_stall_pct = 25;
			end
		endcase
	endtask

	initial begin
		int ph;
		int r;
		int phase_base;
		int dir_a[7];
		int dir_b[6];
		logic [rgmf_pkg::ROW_W-1:0] start;
		dir_a = '{0, 255, 255, 254, 255, 128, 255};
		dir_b = '{255, 1, 255, 255, 255, 7};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of start_row: the earlier white rows must not count
		set_idling(0);
		for (r = 0; r < 73; r++)
			queue_pixel((r == 69 || r == 72) ? 8'h10 : rgmf_pkg::WHITE_LEVEL, 1'b1, r == 72);
		wait_idle();

		write_start_row('0);
		queue_pixel(8'h00, 1'b0, 1'b1);
		queue_pixel(rgmf_pkg::WHITE_LEVEL, 1'b1, 1'b1);
		for (r = 0; r < 7; r++)
			queue_pixel(rgmf_pkg::PIX_W'(dir_a[r]), r != 6, r == 6);
		for (r = 0; r < 6; r++)
			queue_pixel(rgmf_pkg::PIX_W'(dir_b[r]), 1'b1, r == 5);
		queue_pixel(rgmf_pkg::WHITE_LEVEL, 1'b0, 1'b0);
		queue_pixel(rgmf_pkg::WHITE_LEVEL, 1'b1, 1'b0);
		queue_pixel(rgmf_pkg::WHITE_LEVEL, 1'b0, 1'b0);
		queue_pixel(8'h00, 1'b1, 1'b1);
		wait_idle();

		write_start_row(rgmf_pkg::ROW_LAST);
		set_idling(2);
		queue_frame(5, 2, 50, 1'b0);
		wait_idle();

		for (ph = 0; ph < 12; ph++) begin
			if (ph == 5)
				start = rgmf_pkg::ROW_W'($urandom_range(4095, 0));
			else
				start = rgmf_pkg::ROW_W'($urandom_range(6, 0));
			write_start_row(start);
			set_idling(ph % 4);
			phase_base = pixels_queued;
			while (pixels_queued - phase_base < 140) begin
				if ($urandom_range(99, 0) < 12)
					queue_noise_frame($urandom_range(40, 1));
				else
					queue_frame($urandom_range(14, 1), $urandom_range(4, 1),
						$urandom_range(80, 30), $urandom_range(3, 0) == 0);
				// sender holds off until the block has drained
				if ($urandom_range(9, 0) == 0) wait_idle();
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d pixels, %0d frame results, %0d start_row settings",
			pixels_queued, results_checked, settings_written);
		$display("random and ragged frames ran with free flow, sender gaps, receiver stalls and both");
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/rgmf_pkg.sv
src/rgmf_core.sv
src/rgmf_out_reg.sv
src/row_gap_midpoint_finder_top.sv
src/rgmf_checker.sv
verif/row_gap_midpoint_finder_top_test.sv
